### rtl/chs_pkg.sv
// Package for the chained hash attribute store.
// Holds sizes, operation codes and the structs passed along the cell row.
// No dependencies.
package chs_pkg;

  localparam int ENTRY_COUNT = 64;
  localparam int USED_W      = $clog2(ENTRY_COUNT + 1);
  localparam int DATA_W      = 64;

  typedef enum logic [1:0] {
    FUNC_SET       = 2'd0,
    FUNC_DEFINE    = 2'd1,
    FUNC_DEFINE_FN = 2'd2,
    FUNC_GET       = 2'd3
  } chs_func_t;

  // Transaction under work, held steady and broadcast to every cell.
  typedef struct packed {
    chs_func_t          func;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  word;
  } chs_query_t;

  // Search token handed from cell to cell, one hop per cycle.
  typedef struct packed {
    logic               token;
    logic               hit;
    logic [DATA_W-1:0]  value;
  } chs_probe_t;

endpackage

### rtl/chs_cell.sv
// One entry cell of the attribute store row.
// Holds key, value, definition and function flag; compares and forwards the probe.
// Depends on chs_pkg.
module chs_cell (
  input  logic               clk,
  input  logic               rst,
  input  chs_pkg::chs_query_t query,
  input  chs_pkg::chs_probe_t probe_in,
  input  logic               occupied,
  input  logic               ins_en,
  output chs_pkg::chs_probe_t probe_out
);
  import chs_pkg::*;

  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] value;
  logic [DATA_W-1:0] definition;
  logic              is_function;
  logic              match;

  // Keys are unique, so at most one cell in the row matches.
  assign match = probe_in.token && occupied && (key == query.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.token <= 1'b0;
    end else begin
      probe_out.token <= probe_in.token;
    end
    probe_out.hit   <= probe_in.hit | match;
    probe_out.value <= match ? value : probe_in.value;

    if (ins_en) begin
      key         <= query.key;
      value       <= (query.func == FUNC_SET) ? query.word : '0;
      definition  <= (query.func == FUNC_SET) ? '0 : query.word;
      is_function <= (query.func == FUNC_DEFINE_FN);
    end else if (match) begin
      unique case (query.func)
        FUNC_SET: begin
          value <= query.word;
        end
        FUNC_DEFINE, FUNC_DEFINE_FN: begin
          definition  <= query.word;
          is_function <= (query.func == FUNC_DEFINE_FN);
        end
        FUNC_GET: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/chained_hash_attribute_store.sv
// Top level of the chained hash attribute store.
// Runs a search token down a row of chs_cell entries and inserts on a miss.
// Depends on chs_pkg and chs_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | to block  | in_valid/in_stall  | func, attr_key, operand_word
//  out     | from block| out_valid/out_stall| read_value, key_found, table_full
//
// Flow: one transaction at a time. The token visits one cell per cycle, and the
// next transaction is accepted only after the previous result has loaded into
// the output register. The result register loads once the token leaves the
// last cell, so the length of the cell row sets the walk time.
// Reset: rst is synchronous, active high; it empties the table (fill count zero)
// and clears all handshake state. Entry contents are not cleared.
// Stalls: a result waits in the output register under out_stall; the next
// transaction may be accepted and walked meanwhile, and holds before loading its
// result until the output register frees.
//
// A key maps to exactly one bucket by its low bits, and keys are unique across
// the table, so searching every occupied entry for the key returns the same entry
// as walking that key's bucket chain. The row therefore needs no head or link
// storage; entries fill in order, tracked by the fill count.
module chained_hash_attribute_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] attr_key,
  input  logic [63:0] operand_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] read_value,
  output logic        key_found,
  output logic        table_full
);
  import chs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t             state;
  logic               launch;
  chs_query_t         query;
  logic [USED_W-1:0]  used;
  logic [DATA_W-1:0]  res_value;
  logic               res_found;
  logic               res_full;

  chs_probe_t                   probe [ENTRY_COUNT+1];
  logic [ENTRY_COUNT-1:0]       occupied;
  logic [ENTRY_COUNT-1:0]       ins_sel;

  logic accept;
  logic tail_done;
  logic is_write;
  logic is_full;
  logic ins_en;
  logic res_load;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign tail_done = (state == S_WALK) && probe[ENTRY_COUNT].token;
  assign is_write  = (query.func != FUNC_GET);
  assign is_full   = (used == USED_W'(ENTRY_COUNT));
  // Insert at the head slot: the next free entry, taken in order.
  assign ins_en    = tail_done && is_write && !probe[ENTRY_COUNT].hit && !is_full;
  // Load the output register once it is empty or being taken.
  assign res_load  = (state == S_FIN) && (!out_valid || !out_stall);

  // Inject the token at the front of the row.
  assign probe[0].token = launch;
  assign probe[0].hit   = 1'b0;
  assign probe[0].value = '0;

  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      occupied[i] = (USED_W'(i) < used);
      ins_sel[i]  = ins_en && (used == USED_W'(i));
    end
  end

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    chs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .query     (query),
      .probe_in  (probe[g]),
      .occupied  (occupied[g]),
      .ins_en    (ins_sel[g]),
      .probe_out (probe[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      launch <= accept;
      // Drain the output register when taken and nothing new arrives.
      if (out_valid && !out_stall && !res_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (tail_done) begin
            state <= S_FIN;
            if (ins_en) begin
              used <= used + USED_W'(1);
            end
          end
        end
        S_FIN: begin
          // Hold the result until the output register is free.
          if (res_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end

    if (accept) begin
      query.func <= chs_func_t'(func);
      query.key  <= attr_key;
      query.word <= operand_word;
    end
    if (tail_done) begin
      res_found <= probe[ENTRY_COUNT].hit;
      res_full  <= is_write && !probe[ENTRY_COUNT].hit && is_full;
      res_value <= (!is_write && probe[ENTRY_COUNT].hit) ? probe[ENTRY_COUNT].value : '0;
    end
    if (res_load) begin
      read_value <= res_value;
      key_found  <= res_found;
      table_full <= res_full;
    end
  end

endmodule

### tb/sv/tb_chained_hash_attribute_store.sv
// Self-checking testbench for chained_hash_attribute_store.
// Drives set, define, define-function and get transactions, predicts every result
// with a bucket-chain table of its own, and checks all fields. Depends on chs_pkg.
`timescale 1ns / 1ps

module tb_chained_hash_attribute_store;
  import chs_pkg::*;

  localparam int KEY_BUCKETS = 16;
  localparam int NO_SLOT     = ENTRY_COUNT;
  localparam int RANDOM_OPS  = 1930;
  // Settling time at the end, scaled from the length of the cell row.
  localparam int TAIL_CYCLES = 2 * ENTRY_COUNT + 10;

  typedef struct {
    chs_func_t    func;
    logic [63:0]  key;
    logic [63:0]  word;
    int unsigned  gap;
    bit           drain;
  } attr_txn_t;

  typedef struct packed {
    logic [63:0]  read_value;
    logic         key_found;
    logic         table_full;
  } attr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_GET;
  logic [63:0] attr_key = '0;
  logic [63:0] operand_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] read_value;
  logic        key_found;
  logic        table_full;

  chained_hash_attribute_store dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .attr_key     (attr_key),
    .operand_word (operand_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_value   (read_value),
    .key_found    (key_found),
    .table_full   (table_full)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transactions waiting to be driven, and results still owed by the block.
  attr_txn_t    op_queue[$];
  attr_result_t owed_results[$];
  logic [63:0]  used_keys[$];
  int unsigned  fail_count = 0;

  // Shadow of the attribute table: bucket heads, entries in fill order, links.
  int           bucket_head[KEY_BUCKETS];
  logic [63:0]  slot_key[ENTRY_COUNT];
  logic [63:0]  slot_value[ENTRY_COUNT];
  logic [63:0]  slot_def[ENTRY_COUNT];
  bit           slot_is_fn[ENTRY_COUNT];
  int           slot_link[ENTRY_COUNT];
  int           slots_used = 0;

  // Handshake flags passed from the sampling edge to the driving edge.
  bit           in_taken = 1'b0;
  bit           out_taken = 1'b0;
  bit           busy = 1'b0;
  bit           launched = 1'b0;
  attr_txn_t    cur;
  int unsigned  hold = 0;
  int unsigned  stall_left = 0;
  int unsigned  results_seen = 0;

  // Walk the key's bucket chain, apply the operation and return the result.
  function automatic attr_result_t lookup_and_update(attr_txn_t t);
    attr_result_t r;
    int           bkt;
    int           walk;
    int           slot;
    int           steps;
    r     = '0;
    bkt   = int'(t.key % 64'(KEY_BUCKETS));
    walk  = bucket_head[bkt];
    slot  = NO_SLOT;
    steps = 0;
    while (walk != NO_SLOT && steps < ENTRY_COUNT && slot == NO_SLOT) begin
      if (slot_key[walk] == t.key) slot = walk;
      else begin
        walk = slot_link[walk];
        steps++;
      end
    end
    r.key_found = (slot != NO_SLOT);
    if (t.func == FUNC_GET) begin
      if (r.key_found) r.read_value = slot_value[slot];
    end else if (r.key_found) begin
      if (t.func == FUNC_SET) slot_value[slot] = t.word;
      else begin
        slot_def[slot]   = t.word;
        slot_is_fn[slot] = (t.func == FUNC_DEFINE_FN);
      end
    end else if (slots_used >= ENTRY_COUNT) begin
      r.table_full = 1'b1;
    end else begin
      slot_key[slots_used] = t.key;
      if (t.func == FUNC_SET) begin
        slot_value[slots_used] = t.word;
        slot_def[slots_used]   = '0;
        slot_is_fn[slots_used] = 1'b0;
      end else begin
        slot_value[slots_used] = '0;
        slot_def[slots_used]   = t.word;
        slot_is_fn[slots_used] = (t.func == FUNC_DEFINE_FN);
      end
      // Insert at the head of the chain, newest first.
      slot_link[slots_used] = bucket_head[bkt];
      bucket_head[bkt]      = slots_used;
      slots_used++;
    end
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Queue one transaction; every third stretch of 150 runs with no sender gaps.
  function automatic void queue_op(chs_func_t f, logic [63:0] k, logic [63:0] w, bit drain);
    attr_txn_t t;
    t.func  = f;
    t.key   = k;
    t.word  = w;
    t.drain = drain;
    t.gap   = ((op_queue.size() / 150) % 3 == 2) ? 0 : $urandom_range(0, 15);
    op_queue.push_back(t);
    used_keys.push_back(k);
  endfunction

  // Stimulus: a directed opening, then random traffic over a pool of known keys.
  initial begin : stimulus
    logic [63:0] k;
    int unsigned pick;
    for (int i = 0; i < KEY_BUCKETS; i++) bucket_head[i] = NO_SLOT;
    for (int i = 0; i < ENTRY_COUNT; i++) slot_link[i] = NO_SLOT;

    // Get from the empty table, then build a chain of four in bucket zero.
    queue_op(FUNC_GET,       64'd0,  '1, 1'b0);
    queue_op(FUNC_SET,       64'd0,  '1, 1'b0);
    queue_op(FUNC_GET,       64'd0,  '0, 1'b0);
    queue_op(FUNC_SET,       64'd16, 64'd1, 1'b0);
    // New entry by define: value reads back as null.
    queue_op(FUNC_DEFINE,    64'd32, '1, 1'b0);
    queue_op(FUNC_GET,       64'd32, '0, 1'b0);
    queue_op(FUNC_DEFINE_FN, 64'd48, 64'd5, 1'b0);
    // Walk to the far end of the chain.
    queue_op(FUNC_GET,       64'd16, '0, 1'b0);
    queue_op(FUNC_GET,       64'd0,  '0, 1'b0);
    queue_op(FUNC_SET,       64'd32, 64'hA5A5_5A5A_F00F_0FF0, 1'b0);
    queue_op(FUNC_GET,       64'd32, '0, 1'b0);
    // Defining an existing key leaves its value alone.
    queue_op(FUNC_DEFINE_FN, 64'd0,  64'h8000_0000_0000_0001, 1'b0);
    queue_op(FUNC_DEFINE,    64'd48, '0, 1'b0);
    queue_op(FUNC_GET,       64'd0,  '1, 1'b0);
    queue_op(FUNC_GET,       64'd48, '0, 1'b0);
    // All-ones key, and an absent key in bucket zero.
    queue_op(FUNC_SET,       '1,     '0, 1'b0);
    queue_op(FUNC_GET,       '1,     '1, 1'b0);
    queue_op(FUNC_GET,       64'h8000_0000_0000_0000, '0, 1'b0);
    queue_op(FUNC_DEFINE,    '1,     '1, 1'b0);
    queue_op(FUNC_SET,       '1,     64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    queue_op(FUNC_GET,       '1,     '0, 1'b0);

    // Random part: the table fills early, then hits and dropped inserts mix.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) k = used_keys[$urandom_range(0, used_keys.size() - 1)];
      else if (pick < 7) begin
        // Same bucket as a known key, so chains grow long.
        k = rand_word();
        k[3:0] = used_keys[$urandom_range(0, used_keys.size() - 1)][3:0];
      end else k = rand_word();
      queue_op(chs_func_t'($urandom_range(0, 3)), k, rand_word(), (n % 400) == 199);
    end

    // Hold until the last transaction is in and every result is back.
    @(negedge clk);
    while (op_queue.size() != 0 || busy || owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_chained_hash_attribute_store OK");
    else $display("tb_chained_hash_attribute_store NOT OK");
    $finish;
  end

  // Release reset on a falling edge.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_chained_hash_attribute_store NOT OK");
    $finish;
  end

  // Sender: load the next transaction, wait out its gap (and a drain where asked),
  // then hold valid and payload until the block takes it.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        busy     = 1'b0;
        launched = 1'b0;
      end
      if (!busy && op_queue.size() != 0) begin
        cur  = op_queue.pop_front();
        hold = cur.gap;
        busy = 1'b1;
      end
      if (busy && !launched) begin
        if (hold != 0) hold--;
        else if (!cur.drain || owed_results.size() == 0) launched = 1'b1;
      end
      if (busy) begin
        func         <= cur.func;
        attr_key     <= cur.key;
        operand_word <= cur.word;
      end
      in_valid <= launched;
    end
  end

  // Receiver: draw a stall per result and count it down while a result is
  // waiting; the second of every three stretches of 150 results has no stall.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        out_taken  = 1'b0;
        stall_left = ((results_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 15);
      end
      if (stall_left != 0 && out_valid) stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Monitor: predict on every accepted input transaction, check every accepted result.
  always @(posedge clk) begin : monitor
    attr_result_t want;
    attr_txn_t    seen;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.func  = chs_func_t'(func);
        seen.key   = attr_key;
        seen.word  = operand_word;
        seen.gap   = 0;
        seen.drain = 1'b0;
        owed_results.push_back(lookup_and_update(seen));
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value);
            fail_count++;
          end
          if (key_found !== want.key_found) begin
            $error("key_found: expected %b, got %b", want.key_found, key_found);
            fail_count++;
          end
          if (table_full !== want.table_full) begin
            $error("table_full: expected %b, got %b", want.table_full, table_full);
            fail_count++;
          end
        end
      end
    end
  end

endmodule
